[hdl/bsm_pkg.sv]
// Shared widths and lane count for the bounding sphere merge block.
package bsm_pkg;

  localparam int unsigned CoordW  = 32;                 // signed Q16.16 center coordinate
  localparam int unsigned RadW    = 31;                 // unsigned Q15.16 radius
  localparam int unsigned Lanes   = 3;                  // x, y, z
  localparam int unsigned DistW   = 33;                 // distance and shift width
  localparam int unsigned ProdW   = 66;                 // square sums and products
  localparam int unsigned RemW    = 34;                 // root remainder width
  localparam int unsigned CntW    = 6;
  localparam logic [CntW-1:0] MulSteps  = CntW'(CoordW - 1);
  localparam logic [CntW-1:0] RootSteps = CntW'(ProdW / 2 - 1);
  localparam logic [CntW-1:0] DivSteps  = CntW'(CoordW - 1);

endpackage

[hdl/bounding_sphere_merge.sv]
// Bounding sphere merge: folds a run of spheres into one enclosing sphere, bit serially.
// A seeding item passes only the accept and finish states. A merged item runs the squares, the
// sum, the root (two radicand bits a cycle) and the decision, and finishes there when it changes
// nothing or contains the running sphere; when the running sphere grows, the products and the
// quotients follow before the finish. One item is in
// work at a time; a result waits in the output register. Reset clears the running sphere.
module bounding_sphere_merge
  import bsm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [CoordW-1:0] center_x_i,
  input  logic signed [CoordW-1:0] center_y_i,
  input  logic signed [CoordW-1:0] center_z_i,
  input  logic        [RadW-1:0]   radius_i,
  input  logic                     first_of_run_i,
  input  logic                     last_of_run_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [CoordW-1:0] merged_x_o,
  output logic signed [CoordW-1:0] merged_y_o,
  output logic signed [CoordW-1:0] merged_z_o,
  output logic        [RadW-1:0]   merged_radius_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSq   = 3'd1;
  localparam logic [2:0] StSum  = 3'd2;
  localparam logic [2:0] StRoot = 3'd3;
  localparam logic [2:0] StDec  = 3'd4;
  localparam logic [2:0] StMul  = 3'd5;
  localparam logic [2:0] StDiv  = 3'd6;
  localparam logic [2:0] StFin  = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              last_q, last_d;
  logic [RadW-1:0]   in_r_q, in_r_d;
  logic [CoordW-1:0] in_c_q [Lanes];
  logic [CoordW-1:0] in_c_d [Lanes];
  logic              neg_q  [Lanes];
  logic              neg_d  [Lanes];
  logic [CoordW-1:0] mag_q  [Lanes];
  logic [CoordW-1:0] mag_d  [Lanes];
  logic [CoordW-1:0] mpl_q  [Lanes];
  logic [CoordW-1:0] mpl_d  [Lanes];
  logic [DistW-1:0]  mcand_q [Lanes];
  logic [DistW-1:0]  mcand_d [Lanes];
  logic [ProdW-1:0]  acc_q  [Lanes];
  logic [ProdW-1:0]  acc_d  [Lanes];
  logic [CoordW-1:0] run_c_q [Lanes];
  logic [CoordW-1:0] run_c_d [Lanes];
  logic [RadW-1:0]   run_r_q, run_r_d;
  logic [ProdW-1:0]  rad_q, rad_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic [DistW-1:0]  root_q, root_d;
  logic              out_valid_q, out_valid_d;
  logic [CoordW-1:0] out_c_q [Lanes];
  logic [CoordW-1:0] out_c_d [Lanes];
  logic [RadW-1:0]   out_r_q, out_r_d;

  logic [CoordW-1:0] in_c [Lanes];
  logic [CoordW:0]   diff [Lanes];
  logic [RemW+1:0]   rem_sh;
  logic [RemW:0]     trial;
  logic [RemW-1:0]   reach, big_r, d_plus_r, sum_r;
  logic [RemW-1:0]   shift_w;
  logic [RemW-1:0]   div_t;
  logic              div_ge;

  assign in_c[0] = center_x_i;
  assign in_c[1] = center_y_i;
  assign in_c[2] = center_z_i;

  assign in_ready_o = (state_q == StIdle);

  // Running-sphere decision once the distance is known.
  assign reach    = RemW'(root_q) + RemW'(in_r_q);
  assign big_r    = RemW'(run_r_q);
  assign d_plus_r = RemW'(root_q) + big_r;
  assign shift_w  = (reach - big_r) >> 1;
  assign sum_r    = big_r + shift_w;

  assign rem_sh = {rem_q, rad_q[ProdW-1 -: 2]};
  assign trial  = {root_q, 2'b01};

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    in_r_d      = in_r_q;
    run_r_d     = run_r_q;
    rad_d       = rad_q;
    rem_d       = rem_q;
    root_d      = root_q;
    out_valid_d = out_valid_q;
    out_r_d     = out_r_q;
    div_t       = '0;
    div_ge      = 1'b0;
    for (int i = 0; i < Lanes; i++) begin
      in_c_d[i]  = in_c_q[i];
      neg_d[i]   = neg_q[i];
      mag_d[i]   = mag_q[i];
      mpl_d[i]   = mpl_q[i];
      mcand_d[i] = mcand_q[i];
      acc_d[i]   = acc_q[i];
      run_c_d[i] = run_c_q[i];
      out_c_d[i] = out_c_q[i];
      diff[i]    = {in_c[i][CoordW-1], in_c[i]} - {run_c_q[i][CoordW-1], run_c_q[i]};
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          last_d = last_of_run_i;
          in_r_d = radius_i;
          cnt_d  = MulSteps;
          for (int i = 0; i < Lanes; i++) begin
            in_c_d[i]  = in_c[i];
            neg_d[i]   = diff[i][CoordW];
            mag_d[i]   = diff[i][CoordW] ? CoordW'(-diff[i]) : diff[i][CoordW-1:0];
            mpl_d[i]   = mag_d[i];
            mcand_d[i] = DistW'(mag_d[i]);
            acc_d[i]   = '0;
          end
          if (first_of_run_i) begin
            for (int i = 0; i < Lanes; i++) begin
              run_c_d[i] = in_c[i];
            end
            run_r_d = radius_i;
            state_d = StFin;
          end else begin
            state_d = StSq;
          end
        end
      end
      StSq, StMul: begin
        // MSB-first shift and add, one multiplier bit a cycle in each lane.
        for (int i = 0; i < Lanes; i++) begin
          acc_d[i] = {acc_q[i][ProdW-2:0], 1'b0}
                   + (mpl_q[i][CoordW-1] ? ProdW'(mcand_q[i]) : '0);
          mpl_d[i] = {mpl_q[i][CoordW-2:0], 1'b0};
        end
        if (cnt_q == '0) begin
          state_d = (state_q == StSq) ? StSum : StDiv;
          cnt_d   = (state_q == StSq) ? RootSteps : DivSteps;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StSum: begin
        rad_d   = acc_q[0] + acc_q[1] + acc_q[2];
        rem_d   = '0;
        root_d  = '0;
        state_d = StRoot;
      end
      StRoot: begin
        // Restoring square root, two radicand bits a cycle.
        if (rem_sh >= (RemW+2)'(trial)) begin
          rem_d  = RemW'(rem_sh - (RemW+2)'(trial));
          root_d = {root_q[DistW-2:0], 1'b1};
        end else begin
          rem_d  = RemW'(rem_sh);
          root_d = {root_q[DistW-2:0], 1'b0};
        end
        rad_d = {rad_q[ProdW-3:0], 2'b00};
        if (cnt_q == '0) begin
          state_d = StDec;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StDec: begin
        if (reach <= big_r) begin
          state_d = StFin;
        end else if (RemW'(in_r_q) >= d_plus_r) begin
          for (int i = 0; i < Lanes; i++) begin
            run_c_d[i] = in_c_q[i];
          end
          run_r_d = in_r_q;
          state_d = StFin;
        end else begin
          run_r_d = (sum_r[RemW-1:RadW] != '0) ? '1 : sum_r[RadW-1:0];
          for (int i = 0; i < Lanes; i++) begin
            mcand_d[i] = shift_w[DistW-1:0];
            mpl_d[i]   = mag_q[i];
            acc_d[i]   = '0;
          end
          cnt_d   = MulSteps;
          state_d = StMul;
        end
      end
      StDiv: begin
        // Restoring division of the product by d; the quotient shifts into the low word.
        for (int i = 0; i < Lanes; i++) begin
          div_t  = {acc_q[i][ProdW-2:CoordW], acc_q[i][CoordW-1]};
          div_ge = div_t >= RemW'(root_q);
          if (div_ge) begin
            div_t = div_t - RemW'(root_q);
          end
          acc_d[i] = {1'b0, div_t[DistW-1:0], acc_q[i][CoordW-2:0], div_ge};
          if (cnt_q == '0) begin
            run_c_d[i] = neg_q[i] ? run_c_q[i] - acc_d[i][CoordW-1:0]
                                  : run_c_q[i] + acc_d[i][CoordW-1:0];
          end
        end
        if (cnt_q == '0) begin
          state_d = StFin;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StFin: begin
        if (!last_q) begin
          state_d = StIdle;
        end else if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          for (int i = 0; i < Lanes; i++) begin
            out_c_d[i] = run_c_q[i];
          end
          out_r_d = run_r_q;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      run_r_q     <= '0;
      for (int i = 0; i < Lanes; i++) begin
        run_c_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      run_r_q     <= run_r_d;
      for (int i = 0; i < Lanes; i++) begin
        run_c_q[i] <= run_c_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    last_q  <= last_d;
    in_r_q  <= in_r_d;
    rad_q   <= rad_d;
    rem_q   <= rem_d;
    root_q  <= root_d;
    out_r_q <= out_r_d;
    for (int i = 0; i < Lanes; i++) begin
      in_c_q[i]  <= in_c_d[i];
      neg_q[i]   <= neg_d[i];
      mag_q[i]   <= mag_d[i];
      mpl_q[i]   <= mpl_d[i];
      mcand_q[i] <= mcand_d[i];
      acc_q[i]   <= acc_d[i];
      out_c_q[i] <= out_c_d[i];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign merged_x_o      = out_c_q[0];
  assign merged_y_o      = out_c_q[1];
  assign merged_z_o      = out_c_q[2];
  assign merged_radius_o = out_r_q;

  // The partial remainder of the root never exceeds twice the partial root.
  a_root_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRoot |-> (RemW+1)'(rem_q) <= {1'b0, root_q, 1'b0})
    else $error("root remainder out of range");

  // The quotient fits in one coordinate, so the top product bit is clear during division.
  a_div_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDiv |-> acc_q[0][ProdW-1] == 1'b0 && acc_q[1][ProdW-1] == 1'b0
                         && acc_q[2][ProdW-1] == 1'b0)
    else $error("product too wide for quotient");

  // The center step is only taken with a nonzero distance.
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StMul |-> root_q != '0)
    else $error("division by zero distance");

  // A result beat is only raised when an item finishes.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == StFin)
    else $error("result raised outside finish");

endmodule
